### rtl/core/assert_macros.svh
// assertion macros for the rtl of the der key parser, used by drpk_step
// no dependencies; every body is empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked while reset is low
`define DRPK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DRPK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DRPK_ASSERT(lbl, clk, rst, prop, msg)
`define DRPK_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/core/drpk_pkg.sv
// types and constants of the der rsa public key parser
// no dependencies; used by every module of the block
package drpk_pkg;

   localparam int unsigned LEN_ACC_W = 32;

   // der tags
   localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
   localparam logic [7:0] TAG_INTEGER    = 8'h02;
   localparam logic [7:0] TAG_BIT_STRING = 8'h03;
   localparam logic [7:0] BYTE_ZERO      = 8'h00;

   // status codes
   localparam logic [1:0] STATUS_BUSY  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_ERROR = 2'd2;

   typedef enum logic [17:0] {
      PH_OUTER_TAG = 18'h00001,
      PH_OUTER_LEN = 18'h00002,
      PH_FORM_TAG  = 18'h00004,
      PH_ALG_LEN   = 18'h00008,
      PH_ALG_SKIP  = 18'h00010,
      PH_BS_TAG    = 18'h00020,
      PH_BS_LEN    = 18'h00040,
      PH_UNUSED    = 18'h00080,
      PH_INNER_TAG = 18'h00100,
      PH_INNER_LEN = 18'h00200,
      PH_MOD_TAG   = 18'h00400,
      PH_MOD_LEN   = 18'h00800,
      PH_MOD_DATA  = 18'h01000,
      PH_EXP_TAG   = 18'h02000,
      PH_EXP_LEN   = 18'h04000,
      PH_EXP_DATA  = 18'h08000,
      PH_DONE      = 18'h10000,
      PH_ERROR     = 18'h20000
   } phase_type;

   typedef struct packed {
      logic       has_value_byte;
      logic       integer_select;
      logic [7:0] value_byte;
      logic [1:0] status;
   } result_type;

endpackage

### rtl/core/drpk_step.sv
// parser state and the per-byte update of the der rsa public key parser
// depends on drpk_pkg and assert_macros.svh
`include "assert_macros.svh"

module drpk_step #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  logic [7:0]           item_byte,
   input  logic                 item_last,
   output logic                 res_valid,
   output drpk_pkg::result_type res
);

   localparam int unsigned LenCntW = $clog2(MAX_LENGTH_BYTES + 1);
   localparam logic [6:0]  MaxLenBytes = 7'(MAX_LENGTH_BYTES);
   localparam int unsigned AccW = drpk_pkg::LEN_ACC_W;

   drpk_pkg::phase_type phase_ff, phase_in;
   logic [AccW-1:0]     acc_ff, acc_in;
   logic [LenCntW-1:0]  len_left_ff, len_left_in;
   logic [AccW-1:0]     content_left_ff, content_left_in;
   logic                first_ff, first_in;
   logic                reported_ff, reported_in;

   logic            len_fin;
   logic [AccW-1:0] len_val;
   logic [AccW-1:0] acc_shift;
   logic [6:0]      n_bytes;
   logic [1:0]      status;
   logic            has;
   logic            sel;

   assign acc_shift = {acc_ff[AccW-9:0], item_byte};
   assign n_bytes   = item_byte[6:0];

   always_comb begin
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      len_left_in     = len_left_ff;
      content_left_in = content_left_ff;
      first_in        = first_ff;
      reported_in     = reported_ff;
      len_fin         = 1'b0;
      len_val         = '0;
      status          = drpk_pkg::STATUS_BUSY;
      has             = 1'b0;
      sel             = 1'b0;

      unique case (phase_ff)
         drpk_pkg::PH_OUTER_TAG: begin
            phase_in = (item_byte == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_OUTER_LEN
                                                             : drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_FORM_TAG: begin
            if (item_byte == drpk_pkg::TAG_SEQUENCE) begin
               phase_in = drpk_pkg::PH_ALG_LEN;
            end else if (item_byte == drpk_pkg::TAG_INTEGER) begin
               phase_in = drpk_pkg::PH_MOD_LEN;
            end else begin
               phase_in = drpk_pkg::PH_ERROR;
            end
         end
         drpk_pkg::PH_BS_TAG: begin
            phase_in = (item_byte == drpk_pkg::TAG_BIT_STRING) ? drpk_pkg::PH_BS_LEN
                                                               : drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_UNUSED: begin
            phase_in = drpk_pkg::PH_INNER_TAG;
         end
         drpk_pkg::PH_INNER_TAG: begin
            phase_in = (item_byte == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_INNER_LEN
                                                             : drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_MOD_TAG: begin
            phase_in = (item_byte == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_MOD_LEN
                                                            : drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_EXP_TAG: begin
            phase_in = (item_byte == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_EXP_LEN
                                                            : drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_OUTER_LEN, drpk_pkg::PH_ALG_LEN, drpk_pkg::PH_BS_LEN,
         drpk_pkg::PH_INNER_LEN, drpk_pkg::PH_MOD_LEN, drpk_pkg::PH_EXP_LEN: begin
            if (len_left_ff == '0) begin
               if (!item_byte[7]) begin
                  len_fin = 1'b1;
                  len_val = AccW'(item_byte);
               end else if (n_bytes > MaxLenBytes) begin
                  phase_in = drpk_pkg::PH_ERROR;
               end else if (n_bytes == 7'd0) begin
                  len_fin = 1'b1;
               end else begin
                  len_left_in = LenCntW'(n_bytes);
                  acc_in      = '0;
               end
            end else begin
               acc_in      = acc_shift;
               len_left_in = len_left_ff - LenCntW'(1);
               if (len_left_ff == LenCntW'(1)) begin
                  len_fin = 1'b1;
                  len_val = acc_shift;
               end
            end
         end
         drpk_pkg::PH_ALG_SKIP: begin
            content_left_in = content_left_ff - AccW'(1);
            if (content_left_ff == AccW'(1)) begin
               phase_in = drpk_pkg::PH_BS_TAG;
            end
         end
         drpk_pkg::PH_MOD_DATA, drpk_pkg::PH_EXP_DATA: begin
            sel             = (phase_ff == drpk_pkg::PH_EXP_DATA);
            // one leading zero byte of each integer is dropped
            has             = !(first_ff && item_byte == drpk_pkg::BYTE_ZERO);
            first_in        = 1'b0;
            content_left_in = content_left_ff - AccW'(1);
            if (content_left_ff == AccW'(1)) begin
               if (sel) begin
                  phase_in = drpk_pkg::PH_DONE;
                  status   = drpk_pkg::STATUS_DONE;
               end else begin
                  phase_in = drpk_pkg::PH_EXP_TAG;
               end
            end
         end
         default: begin
         end
      endcase

      // finished length field, where it goes depends on the phase
      if (len_fin) begin
         unique case (phase_ff)
            drpk_pkg::PH_OUTER_LEN: phase_in = drpk_pkg::PH_FORM_TAG;
            drpk_pkg::PH_ALG_LEN: begin
               content_left_in = len_val;
               phase_in = (len_val == '0) ? drpk_pkg::PH_BS_TAG : drpk_pkg::PH_ALG_SKIP;
            end
            drpk_pkg::PH_BS_LEN:    phase_in = drpk_pkg::PH_UNUSED;
            drpk_pkg::PH_INNER_LEN: phase_in = drpk_pkg::PH_MOD_TAG;
            drpk_pkg::PH_MOD_LEN: begin
               content_left_in = len_val;
               first_in        = 1'b1;
               phase_in = (len_val == '0) ? drpk_pkg::PH_EXP_TAG : drpk_pkg::PH_MOD_DATA;
            end
            default: begin
               content_left_in = len_val;
               first_in        = 1'b1;
               if (len_val == '0) begin
                  phase_in = drpk_pkg::PH_DONE;
                  status   = drpk_pkg::STATUS_DONE;
               end else begin
                  phase_in = drpk_pkg::PH_EXP_DATA;
               end
            end
         endcase
      end

      if (phase_in == drpk_pkg::PH_ERROR && !reported_ff) begin
         status = drpk_pkg::STATUS_ERROR;
      end
      // final beat before completion is malformed
      if (item_last && !reported_ff && status == drpk_pkg::STATUS_BUSY) begin
         status = drpk_pkg::STATUS_ERROR;
      end
      if (status == drpk_pkg::STATUS_ERROR) begin
         has      = 1'b0;
         phase_in = drpk_pkg::PH_ERROR;
      end
      if (status != drpk_pkg::STATUS_BUSY) begin
         reported_in = 1'b1;
      end

      if (item_last) begin
         phase_in        = drpk_pkg::PH_OUTER_TAG;
         acc_in          = '0;
         len_left_in     = '0;
         content_left_in = '0;
         first_in        = 1'b1;
         reported_in     = 1'b0;
      end
   end

   assign res_valid          = item_valid && (has || status != drpk_pkg::STATUS_BUSY);
   assign res.has_value_byte = has;
   assign res.integer_select = has && sel;
   assign res.value_byte     = has ? item_byte : 8'h00;
   assign res.status         = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= drpk_pkg::PH_OUTER_TAG;
         acc_ff          <= '0;
         len_left_ff     <= '0;
         content_left_ff <= '0;
         first_ff        <= 1'b1;
         reported_ff     <= 1'b0;
      end else if (item_valid) begin
         phase_ff        <= phase_in;
         acc_ff          <= acc_in;
         len_left_ff     <= len_left_in;
         content_left_ff <= content_left_in;
         first_ff        <= first_in;
         reported_ff     <= reported_in;
      end
   end

   `DRPK_ASSERT(a_err_no_value, clock, reset,
      res_valid && res.status == drpk_pkg::STATUS_ERROR |-> !res.has_value_byte,
      "error result carries a value byte")
   `DRPK_ASSERT(a_last_restarts, clock, reset,
      item_valid && item_last |=> phase_ff == drpk_pkg::PH_OUTER_TAG && !reported_ff,
      "final beat did not restart the parser")
   `DRPK_ASSERT(a_quiet_after_report, clock, reset,
      item_valid && reported_ff && !item_last |-> !res_valid,
      "result after completion or error was reported")
   `DRPK_ASSERT(a_value_in_data, clock, reset,
      res_valid && res.has_value_byte |->
         phase_ff == drpk_pkg::PH_MOD_DATA || phase_ff == drpk_pkg::PH_EXP_DATA,
      "value byte outside integer content")
   `DRPK_ASSERT_ALWAYS(a_reset_clears_report, clock,
      $past(reset) |-> !reported_ff,
      "report flag survived reset")

endmodule

### rtl/core/drpk_out_reg.sv
// result register of the der rsa public key parser
// depends on drpk_pkg
module drpk_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  drpk_pkg::result_type load_data,
   output logic                 free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output drpk_pkg::result_type out_data
);

   logic                 valid_ff, valid_in;
   drpk_pkg::result_type data_ff;

   // empty, or the waiting beat leaves this cycle
   assign free = !valid_ff || out_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/core/der_rsa_public_key_parser_unit.sv
// der rsa public key parser: input register, per-byte parser, result register
// req beats pass the input register, the parser and the result register in order
// throughput: one byte per cycle while the result register is free (empty or read)
// a byte that yields neither a value byte nor a status gives no rsp beat
// reset (synchronous, active high) empties both registers and restarts the parser
// depends on drpk_pkg, drpk_step and drpk_out_reg
module der_rsa_public_key_parser_unit #(
   parameter int unsigned MAX_LENGTH_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_key
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] value_byte, [9:8] status, [15:10] zero
   output logic [1:0]  rsp_tuser    // [0] has_value_byte, [1] integer_select
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                 out_free;
   logic                 step_fire;
   logic                 res_valid;
   drpk_pkg::result_type res;
   drpk_pkg::result_type rsp_res;

   assign req_tready = !in_valid_ff || out_free;
   assign step_fire  = in_valid_ff && out_free;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   drpk_step #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .item_valid (step_fire),
      .item_byte  (in_byte_ff),
      .item_last  (in_last_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   drpk_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   assign rsp_tdata = {6'b000000, rsp_res.status, rsp_res.value_byte};
   assign rsp_tuser = {rsp_res.integer_select, rsp_res.has_value_byte};

endmodule

### tb/testbench.sv
// self-checking testbench for der_rsa_public_key_parser_unit: directed table, then random keys
// predicts rsp beats with its own byte-level parser model or takes them from the table; depends on drpk_pkg and the rtl
`timescale 1ns / 1ps

module testbench;

   localparam int LEN_BYTES_MAX = 4;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 250;
   localparam int STALL_LIMIT   = 2000;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_check_type;

   typedef struct packed {
      logic [7:0]           data;
      logic                 last;
      row_check_type        check;
      drpk_pkg::result_type want;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tlast = 1'b0;   // end_of_key
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] value_byte, [9:8] status, [15:10] zero
   logic [1:0]  rsp_tuser;          // [0] has_value_byte, [1] integer_select

   // parser model state
   drpk_pkg::phase_type p_phase;
   logic [31:0]         p_len_acc;
   logic [2:0]          p_len_left;
   logic [31:0]         p_content_left;
   logic                p_first;
   logic                p_reported;

   drpk_pkg::result_type awaited_results[$];
   logic [7:0]           key_bytes[$];

   int error_count = 0;
   int results_checked = 0;
   int bytes_sent = 0;
   int send_idle_pct = 6;
   int recv_idle_pct = 73;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // raw key: leading zero dropped, empty exponent completes on the final byte
      '{8'h30, 1'b0, ROW_NONE,    '0},
      '{8'h06, 1'b0, ROW_PREDICT, '0},
      '{8'h02, 1'b0, ROW_PREDICT, '0},
      '{8'h02, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_NONE,    '0},
      '{8'hFF, 1'b0, ROW_RESULT,  '{1'b1, 1'b0, 8'hFF, drpk_pkg::STATUS_BUSY}},
      '{8'h02, 1'b0, ROW_PREDICT, '0},
      '{8'h80, 1'b1, ROW_RESULT,  '{1'b0, 1'b0, 8'h00, drpk_pkg::STATUS_DONE}},
      // wrapped key that ends on a modulus byte
      '{8'h30, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_PREDICT, '0},
      '{8'h30, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_PREDICT, '0},
      '{8'h03, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_PREDICT, '0},
      '{8'h7F, 1'b0, ROW_PREDICT, '0},
      '{8'h30, 1'b0, ROW_PREDICT, '0},
      '{8'h00, 1'b0, ROW_PREDICT, '0},
      '{8'h02, 1'b0, ROW_PREDICT, '0},
      '{8'h01, 1'b0, ROW_PREDICT, '0},
      '{8'hAA, 1'b1, ROW_RESULT,  '{1'b0, 1'b0, 8'h00, drpk_pkg::STATUS_ERROR}},
      // bad outer tag, then an ignored final byte
      '{8'h05, 1'b0, ROW_RESULT,  '{1'b0, 1'b0, 8'h00, drpk_pkg::STATUS_ERROR}},
      '{8'hFF, 1'b1, ROW_NONE,    '0},
      // five length bytes announced
      '{8'h30, 1'b0, ROW_PREDICT, '0},
      '{8'h85, 1'b1, ROW_RESULT,  '{1'b0, 1'b0, 8'h00, drpk_pkg::STATUS_ERROR}}
   };

   der_rsa_public_key_parser_unit #(.MAX_LENGTH_BYTES(LEN_BYTES_MAX)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void restart_parser();
      p_phase        = drpk_pkg::PH_OUTER_TAG;
      p_len_acc      = '0;
      p_len_left     = '0;
      p_content_left = '0;
      p_first        = 1'b1;
      p_reported     = 1'b0;
   endfunction

   // a length field is complete; returns the status it raises
   function automatic logic [1:0] end_length(input logic [31:0] len);
      case (p_phase)
         drpk_pkg::PH_OUTER_LEN: p_phase = drpk_pkg::PH_FORM_TAG;
         drpk_pkg::PH_ALG_LEN: begin
            p_content_left = len;
            p_phase = (len == 0) ? drpk_pkg::PH_BS_TAG : drpk_pkg::PH_ALG_SKIP;
         end
         drpk_pkg::PH_BS_LEN: p_phase = drpk_pkg::PH_UNUSED;
         drpk_pkg::PH_INNER_LEN: p_phase = drpk_pkg::PH_MOD_TAG;
         drpk_pkg::PH_MOD_LEN: begin
            p_content_left = len;
            p_first = 1'b1;
            p_phase = (len == 0) ? drpk_pkg::PH_EXP_TAG : drpk_pkg::PH_MOD_DATA;
         end
         default: begin
            p_content_left = len;
            p_first = 1'b1;
            if (len == 0) begin
               p_phase = drpk_pkg::PH_DONE;
               return drpk_pkg::STATUS_DONE;
            end
            p_phase = drpk_pkg::PH_EXP_DATA;
         end
      endcase
      return drpk_pkg::STATUS_BUSY;
   endfunction

   // one byte through the parser model; returns 1 when a rsp beat is due
   function automatic logic parse_byte(input logic [7:0] b, input logic last,
                                       output drpk_pkg::result_type r);
      logic [6:0] n;
      r = '0;
      n = b[6:0];
      case (p_phase)
         drpk_pkg::PH_OUTER_TAG:
            p_phase = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_OUTER_LEN
                                                    : drpk_pkg::PH_ERROR;
         drpk_pkg::PH_FORM_TAG: begin
            if (b == drpk_pkg::TAG_SEQUENCE) p_phase = drpk_pkg::PH_ALG_LEN;
            else if (b == drpk_pkg::TAG_INTEGER) p_phase = drpk_pkg::PH_MOD_LEN;
            else p_phase = drpk_pkg::PH_ERROR;
         end
         drpk_pkg::PH_BS_TAG:
            p_phase = (b == drpk_pkg::TAG_BIT_STRING) ? drpk_pkg::PH_BS_LEN
                                                      : drpk_pkg::PH_ERROR;
         drpk_pkg::PH_UNUSED: p_phase = drpk_pkg::PH_INNER_TAG;
         drpk_pkg::PH_INNER_TAG:
            p_phase = (b == drpk_pkg::TAG_SEQUENCE) ? drpk_pkg::PH_INNER_LEN
                                                    : drpk_pkg::PH_ERROR;
         drpk_pkg::PH_MOD_TAG:
            p_phase = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_MOD_LEN
                                                   : drpk_pkg::PH_ERROR;
         drpk_pkg::PH_EXP_TAG:
            p_phase = (b == drpk_pkg::TAG_INTEGER) ? drpk_pkg::PH_EXP_LEN
                                                   : drpk_pkg::PH_ERROR;
         drpk_pkg::PH_OUTER_LEN, drpk_pkg::PH_ALG_LEN, drpk_pkg::PH_BS_LEN,
         drpk_pkg::PH_INNER_LEN, drpk_pkg::PH_MOD_LEN, drpk_pkg::PH_EXP_LEN: begin
            if (p_len_left == 0) begin
               if (!b[7]) r.status = end_length({24'd0, b});
               else if (n > LEN_BYTES_MAX) p_phase = drpk_pkg::PH_ERROR;
               else if (n == 0) r.status = end_length(32'd0);
               else begin
                  p_len_left = n[2:0];
                  p_len_acc = '0;
               end
            end else begin
               p_len_acc = {p_len_acc[23:0], b};
               p_len_left = p_len_left - 1'b1;
               if (p_len_left == 0) r.status = end_length(p_len_acc);
            end
         end
         drpk_pkg::PH_ALG_SKIP: begin
            p_content_left = p_content_left - 1;
            if (p_content_left == 0) p_phase = drpk_pkg::PH_BS_TAG;
         end
         drpk_pkg::PH_MOD_DATA, drpk_pkg::PH_EXP_DATA: begin
            r.integer_select = (p_phase == drpk_pkg::PH_EXP_DATA);
            if (!(p_first && b == drpk_pkg::BYTE_ZERO)) begin
               r.has_value_byte = 1'b1;
               r.value_byte = b;
            end
            p_first = 1'b0;
            p_content_left = p_content_left - 1;
            if (p_content_left == 0) begin
               if (r.integer_select) begin
                  p_phase = drpk_pkg::PH_DONE;
                  r.status = drpk_pkg::STATUS_DONE;
               end else begin
                  p_phase = drpk_pkg::PH_EXP_TAG;
               end
            end
         end
         default: ;
      endcase
      if (p_phase == drpk_pkg::PH_ERROR && !p_reported) r.status = drpk_pkg::STATUS_ERROR;
      if (last && !p_reported && r.status == drpk_pkg::STATUS_BUSY)
         r.status = drpk_pkg::STATUS_ERROR;
      if (r.status == drpk_pkg::STATUS_ERROR) begin
         r.has_value_byte = 1'b0;
         r.integer_select = 1'b0;
         r.value_byte = 8'd0;
         p_phase = drpk_pkg::PH_ERROR;
      end
      if (r.status != drpk_pkg::STATUS_BUSY) p_reported = 1'b1;
      if (!r.has_value_byte) r.integer_select = 1'b0;
      if (last) restart_parser();
      return r.has_value_byte || r.status != drpk_pkg::STATUS_BUSY;
   endfunction

   // short, zero or long form, long form sometimes padded with leading zeros
   function automatic void put_length(input int unsigned len);
      int unsigned n_min;
      int unsigned n;
      n_min = (len > 32'hFFFFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
      if (len == 0 && $urandom_range(2) == 0) begin
         key_bytes.push_back(8'h80);
      end else if (len < 128 && $urandom_range(3) != 0) begin
         key_bytes.push_back(8'(len));
      end else begin
         n = $urandom_range(LEN_BYTES_MAX, n_min);
         key_bytes.push_back(8'(32'h80 | n));
         for (int i = n - 1; i >= 0; i--) key_bytes.push_back(8'(len >> (8 * i)));
      end
   endfunction

   function automatic int unsigned ignored_length();
      return ($urandom_range(3) == 0) ? $urandom() : $urandom_range(300);
   endfunction

   function automatic void put_integer(input int unsigned len);
      key_bytes.push_back(drpk_pkg::TAG_INTEGER);
      put_length(len);
      for (int i = 0; i < len; i++) begin
         if (i == 0 && $urandom_range(2) == 0) key_bytes.push_back(drpk_pkg::BYTE_ZERO);
         else key_bytes.push_back(8'($urandom_range(255)));
      end
   endfunction

   // well-formed key with random content, raw or wrapped, then up to two trailing bytes
   function automatic void build_key();
      int unsigned alg_len;
      int unsigned mod_len;
      int unsigned pick;
      key_bytes.delete();
      pick = $urandom_range(19);
      mod_len = (pick == 0) ? 0 : (pick < 17) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      key_bytes.push_back(drpk_pkg::TAG_SEQUENCE);
      put_length(ignored_length());
      if ($urandom_range(1)) begin
         key_bytes.push_back(drpk_pkg::TAG_SEQUENCE);
         alg_len = $urandom_range(6);
         put_length(alg_len);
         repeat (alg_len) key_bytes.push_back(8'($urandom_range(255)));
         key_bytes.push_back(drpk_pkg::TAG_BIT_STRING);
         put_length(ignored_length());
         key_bytes.push_back(8'($urandom_range(255)));
         key_bytes.push_back(drpk_pkg::TAG_SEQUENCE);
         put_length(ignored_length());
      end
      put_integer(mod_len);
      put_integer($urandom_range(4));
      repeat ($urandom_range(2)) key_bytes.push_back(8'($urandom_range(255)));
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      $display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   task automatic offer_byte(input logic [7:0] b, input logic last,
                             input row_check_type check, input drpk_pkg::result_type want);
      drpk_pkg::result_type predicted;
      logic                 due;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      due = parse_byte(b, last, predicted);
      case (check)
         ROW_PREDICT: if (due) awaited_results.push_back(predicted);
         ROW_RESULT:  awaited_results.push_back(want);
         default: ;
      endcase
   endtask

   // sender goes quiet until every awaited beat is back and the pipe is empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: check, then pick ready for the next edge
   always @(posedge clock) begin : rsp_side
      drpk_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (awaited_results.size() == 0) begin
            report_mismatch("beat with nothing awaited", rsp_tdata, 0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser[0] !== want.has_value_byte)
               report_mismatch("has_value_byte", rsp_tuser[0], want.has_value_byte);
            if (rsp_tuser[1] !== want.integer_select)
               report_mismatch("integer_select", rsp_tuser[1], want.integer_select);
            if (rsp_tdata[7:0] !== want.value_byte)
               report_mismatch("value_byte", rsp_tdata[7:0], want.value_byte);
            if (rsp_tdata[9:8] !== want.status)
               report_mismatch("status", rsp_tdata[9:8], want.status);
            if (rsp_tdata[15:10] !== 6'd0)
               report_mismatch("tdata padding", rsp_tdata[15:10], 0);
         end
      end
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned pick;
      int unsigned cut;
      int keys_whole;
      int keys_damaged;
      int noise_runs;
      keys_whole = 0;
      keys_damaged = 0;
      noise_runs = 0;
      restart_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_byte(directed_rows[i].data, directed_rows[i].last,
                    directed_rows[i].check, directed_rows[i].want);
      drain_results();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 6;  recv_idle_pct = 73; end
            1: begin send_idle_pct = 73; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         // long receiver stall while bytes keep coming
         if (ph == 2) holds_asked <= holds_asked + 1;
         while (bytes_sent < DIRECTED_ROWS + (ph + 1) * RANDOM_ITEMS / 3) begin
            pick = $urandom_range(99);
            if (pick >= 90) begin
               key_bytes.delete();
               repeat ($urandom_range(10, 1)) key_bytes.push_back(8'($urandom_range(255)));
               noise_runs++;
            end else begin
               build_key();
               if (pick >= 70) begin
                  keys_damaged++;
                  case ($urandom_range(2))
                     0: begin
                        cut = $urandom_range(key_bytes.size() - 1);
                        key_bytes = key_bytes[0:cut];
                     end
                     1: key_bytes[$urandom_range(key_bytes.size() - 1)] = 8'($urandom_range(255));
                     default: key_bytes[$urandom_range(key_bytes.size() - 1)] =
                                 8'($urandom_range(255, 8'h85));
                  endcase
               end else begin
                  keys_whole++;
               end
            end
            foreach (key_bytes[i])
               offer_byte(key_bytes[i], i == key_bytes.size() - 1, ROW_PREDICT, '0);
         end
         drain_results();
      end

      if (awaited_results.size() != 0)
         report_mismatch("beats never delivered", 0, awaited_results.size());
      $display("sent %0d key bytes: %0d whole keys, %0d damaged keys, %0d noise runs",
               bytes_sent, keys_whole, keys_damaged, noise_runs);
      $display("compared %0d result beats, %0d mismatches", results_checked, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/drpk_pkg.sv
rtl/core/drpk_step.sv
rtl/core/drpk_out_reg.sv
rtl/core/der_rsa_public_key_parser_unit.sv
tb/testbench.sv
